// File: rtl/rtrb_pkg.sv
// Package for the timestamped receive ring buffer.
// Holds item field widths, operation codes and the stats struct.
// No dependencies.
package rtrb_pkg;

  localparam int OP_W    = 2;
  localparam int FLAGS_W = 4;
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 64;
  localparam int CNT_W   = 32;
  localparam int EPOCH_W = 32;

  // Entry word in ring memory: {stamp, epoch, value}
  localparam int ENTRY_W = TIME_W + EPOCH_W + BYTE_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_STATUS = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE   = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  // Error flag bit positions
  localparam int FLAG_OVERFLOW = 0;
  localparam int FLAG_FRAMING  = 1;
  localparam int FLAG_PARITY   = 2;
  localparam int FLAG_BREAK    = 3;

  // Events handed from the ring control to the stats block
  typedef struct packed {
    logic               status_stb;
    logic               byte_stb;
    logic               drop;
    logic [FLAGS_W-1:0] flags;
    logic [BYTE_W-1:0]  batch_len;
  } stats_ev_t;

  // Running counters and epoch
  typedef struct packed {
    logic [CNT_W-1:0]   byte_total;
    logic [CNT_W-1:0]   drop_total;
    logic [CNT_W-1:0]   overflow_total;
    logic [CNT_W-1:0]   framing_total;
    logic [CNT_W-1:0]   parity_total;
    logic [CNT_W-1:0]   break_total;
    logic [EPOCH_W-1:0] epoch;
    logic [BYTE_W-1:0]  batch_peak;
  } stats_t;

endpackage

// File: rtl/rtrb_if.sv
// Channel interfaces for the timestamped receive ring buffer.
// rtrb_in_if carries input beats, rtrb_out_if carries result beats.
// Depends on rtrb_pkg.
interface rtrb_in_if import rtrb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FLAGS_W-1:0] error_flags;
  logic [BYTE_W-1:0]  batch_len;
  logic [BYTE_W-1:0]  byte_value;
  logic [TIME_W-1:0]  arrival_time;

  modport source (
    output valid, op, error_flags, batch_len, byte_value, arrival_time,
    input  ready
  );
  modport sink (
    input  valid, op, error_flags, batch_len, byte_value, arrival_time,
    output ready
  );
endinterface

interface rtrb_out_if import rtrb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               pop_valid;
  logic [TIME_W-1:0]  pop_time;
  logic [EPOCH_W-1:0] pop_epoch;
  logic [BYTE_W-1:0]  pop_value;
  logic [CNT_W-1:0]   byte_total;
  logic [CNT_W-1:0]   drop_total;
  logic [CNT_W-1:0]   overflow_total;
  logic [CNT_W-1:0]   framing_total;
  logic [CNT_W-1:0]   parity_total;
  logic [CNT_W-1:0]   break_total;
  logic [BYTE_W-1:0]  batch_peak;

  modport source (
    output valid, pop_valid, pop_time, pop_epoch, pop_value, byte_total,
           drop_total, overflow_total, framing_total, parity_total,
           break_total, batch_peak,
    input  ready
  );
  modport sink (
    input  valid, pop_valid, pop_time, pop_epoch, pop_value, byte_total,
           drop_total, overflow_total, framing_total, parity_total,
           break_total, batch_peak,
    output ready
  );
endinterface

// File: rtl/rtrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rtrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/rtrb_stats.sv
// Event counters, error epoch and peak batch length.
// Depends on rtrb_pkg.
module rtrb_stats import rtrb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  stats_ev_t ev,
  output stats_t    stats
);

  stats_t stats_next;

  // Counter update for one accepted beat
  always_comb begin
    stats_next = stats;
    if (ev.byte_stb) begin
      stats_next.byte_total = stats.byte_total + 1'b1;
      if (ev.drop) begin
        stats_next.drop_total = stats.drop_total + 1'b1;
        stats_next.epoch      = stats.epoch + 1'b1;
      end
    end
    if (ev.status_stb) begin
      if (ev.flags != '0) begin
        if (ev.flags[FLAG_OVERFLOW]) stats_next.overflow_total = stats.overflow_total + 1'b1;
        if (ev.flags[FLAG_FRAMING])  stats_next.framing_total  = stats.framing_total + 1'b1;
        if (ev.flags[FLAG_PARITY])   stats_next.parity_total   = stats.parity_total + 1'b1;
        if (ev.flags[FLAG_BREAK])    stats_next.break_total    = stats.break_total + 1'b1;
        stats_next.epoch = stats.epoch + 1'b1;
      end else if (ev.batch_len > stats.batch_peak) begin
        stats_next.batch_peak = ev.batch_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else begin
      stats <= stats_next;
    end
  end

endmodule

// File: rtl/timestamped_rx_ring_buffer.sv
// Timestamped receive ring buffer, top level.
// Usage:
//   req (rtrb_in_if sink): one beat per event; op selects status, received
//     byte or pop. rsp (rtrb_out_if source): exactly one result beat per
//     request beat, in order, carrying the pop fields and all counters.
//   Each request is handled in order: the accept cycle issues the read or
//   write of the entry memory, the next cycle loads the result register
//   from the registered read. No new request is taken while one is in
//   flight, nor while a waiting result has not been taken.
//   Result: the accept sets the in-flight flag pend, and pend sets rsp.valid
//   and loads the result register; the result beat is taken with rsp.ready.
//   Stall: the result register holds while rsp.ready is low; req.ready
//   drops until the waiting result is taken (a request is taken in the
//   same cycle the previous result leaves).
//   Reset (rst, synchronous): clears head/tail pointers, counters, epoch
//   and peak; memory contents are left as they are and need no clearing.
//   The ring keeps one slot empty, so it holds RING_DEPTH-1 entries.
// Depends on rtrb_pkg, rtrb_if, rtrb_ram, rtrb_stats.
module timestamped_rx_ring_buffer import rtrb_pkg::*; #(
  parameter int RING_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  rtrb_in_if.sink     req,
  rtrb_out_if.source  rsp
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   head_inc;
  logic [IDX_W-1:0]   tail_inc;
  logic               pend;
  logic               pend_pop;
  logic               accept;
  logic               ring_full;
  logic               ring_empty;
  logic               is_status;
  logic               is_byte;
  logic               is_pop;
  logic               wr_en;
  logic               rd_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  stats_ev_t          ev;
  stats_t             stats;

  // Handshake: one request in flight, result register must be free next cycle
  assign req.ready = !pend && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign is_status = (req.op == OP_STATUS);
  assign is_byte   = (req.op == OP_BYTE);
  assign is_pop    = (req.op == OP_POP);

  // Ring pointer arithmetic
  assign head_inc   = (head == IDX_LAST) ? '0 : head + 1'b1;
  assign tail_inc   = (tail == IDX_LAST) ? '0 : tail + 1'b1;
  assign ring_full  = (tail_inc == head);
  assign ring_empty = (head == tail);

  // Memory access issued in the accept cycle
  assign wr_en   = accept && is_byte && !ring_full;
  assign rd_en   = accept && is_pop && !ring_empty;
  assign wr_data = {req.arrival_time, stats.epoch, req.byte_value};

  rtrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (head),
    .rdata (rd_data)
  );

  // Events for the counters
  always_comb begin
    ev.status_stb = accept && is_status;
    ev.byte_stb   = accept && is_byte;
    ev.drop       = ring_full;
    ev.flags      = req.error_flags;
    ev.batch_len  = req.batch_len;
  end

  rtrb_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .ev    (ev),
    .stats (stats)
  );

  // Pointers and in-flight flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      pend     <= 1'b0;
      pend_pop <= 1'b0;
    end else begin
      pend     <= accept;
      pend_pop <= rd_en;
      if (wr_en) begin
        tail <= tail_inc;
      end
      if (rd_en) begin
        head <= head_inc;
      end
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (pend) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Result payload, loaded once the memory read data is available
  always_ff @(posedge clk) begin
    if (pend) begin
      rsp.pop_valid      <= pend_pop;
      rsp.pop_time       <= pend_pop ? rd_data[ENTRY_W-1 -: TIME_W] : '0;
      rsp.pop_epoch      <= pend_pop ? rd_data[BYTE_W +: EPOCH_W] : '0;
      rsp.pop_value      <= pend_pop ? rd_data[BYTE_W-1:0] : '0;
      rsp.byte_total     <= stats.byte_total;
      rsp.drop_total     <= stats.drop_total;
      rsp.overflow_total <= stats.overflow_total;
      rsp.framing_total  <= stats.framing_total;
      rsp.parity_total   <= stats.parity_total;
      rsp.break_total    <= stats.break_total;
      rsp.batch_peak     <= stats.batch_peak;
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for timestamped_rx_ring_buffer: a ring and counter model
// predicts every result beat, which a checker compares field by field.
// Depends on rtrb_pkg, rtrb_if (rtrb_in_if, rtrb_out_if) and the block's RTL.
module testbench;
  import rtrb_pkg::*;

  localparam int RING_SLOTS       = 1024;
  localparam int RANDOM_ITEMS     = 520;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 8;

  // Op code the block must ignore
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FLAGS_W-1:0] error_flags;
    logic [BYTE_W-1:0]  batch_len;
    logic [BYTE_W-1:0]  byte_value;
    logic [TIME_W-1:0]  arrival_time;
  } rx_item_t;

  typedef struct packed {
    logic               pop_valid;
    logic [TIME_W-1:0]  pop_time;
    logic [EPOCH_W-1:0] pop_epoch;
    logic [BYTE_W-1:0]  pop_value;
    logic [CNT_W-1:0]   byte_total;
    logic [CNT_W-1:0]   drop_total;
    logic [CNT_W-1:0]   overflow_total;
    logic [CNT_W-1:0]   framing_total;
    logic [CNT_W-1:0]   parity_total;
    logic [CNT_W-1:0]   break_total;
    logic [BYTE_W-1:0]  batch_peak;
  } rx_result_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_e;
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;

  logic clk = 1'b0;
  logic rst;

  rtrb_in_if  req();
  rtrb_out_if rsp();

  timestamped_rx_ring_buffer #(
    .RING_DEPTH(RING_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow ring and counters
  logic [TIME_W-1:0]  ring_stamp [RING_SLOTS];
  logic [EPOCH_W-1:0] ring_epoch_tag [RING_SLOTS];
  logic [BYTE_W-1:0]  ring_value [RING_SLOTS];
  int unsigned        ring_head;
  int unsigned        ring_tail;
  logic [EPOCH_W-1:0] epoch_now;
  logic [CNT_W-1:0]   bytes_seen;
  logic [CNT_W-1:0]   bytes_dropped;
  logic [CNT_W-1:0]   overflow_seen;
  logic [CNT_W-1:0]   framing_seen;
  logic [CNT_W-1:0]   parity_seen;
  logic [CNT_W-1:0]   break_seen;
  logic [BYTE_W-1:0]  peak_len;

  rx_result_t  rx_results_due[$];
  int          error_count = 0;
  int unsigned results_checked = 0;
  int unsigned pops_with_data = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned quiet_cycles = 0;
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_phase = 0;

  // Applies one accepted beat to the shadow state, returns the result it must produce
  function automatic rx_result_t predict_rx_result(input rx_item_t it);
    rx_result_t  res;
    int unsigned next_tail;
    res = '0;
    next_tail = (ring_tail + 1) % RING_SLOTS;
    case (it.op)
      OP_STATUS: begin
        if (it.error_flags != '0) begin
          if (it.error_flags[FLAG_OVERFLOW]) overflow_seen++;
          if (it.error_flags[FLAG_FRAMING])  framing_seen++;
          if (it.error_flags[FLAG_PARITY])   parity_seen++;
          if (it.error_flags[FLAG_BREAK])    break_seen++;
          epoch_now++;
        end else if (it.batch_len > peak_len) begin
          peak_len = it.batch_len;
        end
      end
      OP_BYTE: begin
        bytes_seen++;
        if (next_tail == ring_head) begin
          // ring full: drop, new epoch
          bytes_dropped++;
          epoch_now++;
        end else begin
          ring_stamp[ring_tail]     = it.arrival_time;
          ring_epoch_tag[ring_tail] = epoch_now;
          ring_value[ring_tail]     = it.byte_value;
          ring_tail                 = next_tail;
        end
      end
      OP_POP: begin
        if (ring_head != ring_tail) begin
          res.pop_valid = 1'b1;
          res.pop_time  = ring_stamp[ring_head];
          res.pop_epoch = ring_epoch_tag[ring_head];
          res.pop_value = ring_value[ring_head];
          ring_head     = (ring_head + 1) % RING_SLOTS;
        end
      end
      default: ;
    endcase
    res.byte_total     = bytes_seen;
    res.drop_total     = bytes_dropped;
    res.overflow_total = overflow_seen;
    res.framing_total  = framing_seen;
    res.parity_total   = parity_seen;
    res.break_total    = break_seen;
    res.batch_peak     = peak_len;
    return res;
  endfunction

  function automatic rx_item_t item_of(input logic [OP_W-1:0] op,
                                       input logic [FLAGS_W-1:0] flags,
                                       input logic [BYTE_W-1:0] len,
                                       input logic [BYTE_W-1:0] value,
                                       input logic [TIME_W-1:0] stamp);
    rx_item_t it;
    it.op           = op;
    it.error_flags  = flags;
    it.batch_len    = len;
    it.byte_value   = value;
    it.arrival_time = stamp;
    return it;
  endfunction

  // Random content; half the status beats are clean, lengths lean small
  function automatic rx_item_t rand_item(input logic [OP_W-1:0] op);
    rx_item_t it;
    it.op           = op;
    it.error_flags  = ($urandom_range(0, 1) == 0) ? '0 : FLAGS_W'($urandom_range(1, 15));
    it.batch_len    = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                  : BYTE_W'($urandom_range(0, 60));
    it.byte_value   = BYTE_W'($urandom);
    it.arrival_time = {$urandom, $urandom};
    return it;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input op_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_RESERVED;
    case (mix)
      MIX_FILL:  return (roll < 70) ? OP_BYTE : (roll < 85) ? OP_POP : OP_STATUS;
      MIX_DRAIN: return (roll < 25) ? OP_BYTE : (roll < 85) ? OP_POP : OP_STATUS;
      default:   return (roll < 45) ? OP_BYTE : (roll < 80) ? OP_POP : OP_STATUS;
    endcase
  endfunction

  // Sends one beat; bursts of random length with random gaps in between
  task automatic send_item(input rx_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid        <= 1'b1;
    req.op           <= it.op;
    req.error_flags  <= it.error_flags;
    req.batch_len    <= it.batch_len;
    req.byte_value   <= it.byte_value;
    req.arrival_time <= it.arrival_time;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    rx_results_due.push_back(predict_rx_result(it));
    items_sent++;
  endtask

  // Field extremes, every op and each corner of the status and pop paths
  task automatic test_directed();
    send_item(item_of(OP_POP, '0, '0, '0, '0));              // pop on empty ring
    send_item(item_of(OP_RESERVED, '1, '1, '1, '1));         // ignored op
    send_item(item_of(OP_STATUS, '0, 8'd100, '0, '0));       // peak rises
    send_item(item_of(OP_STATUS, 4'h1, 8'd200, '0, '0));     // errors: length ignored
    send_item(item_of(OP_STATUS, 4'h2, 8'd255, '1, '1));
    send_item(item_of(OP_STATUS, 4'h4, 8'd255, '0, '0));
    send_item(item_of(OP_STATUS, 4'h8, 8'd255, '0, '0));
    send_item(item_of(OP_STATUS, 4'hF, 8'd255, '0, '0));     // all flags at once
    send_item(item_of(OP_STATUS, '0, 8'd17, '0, '0));        // smaller, peak holds
    send_item(item_of(OP_STATUS, '0, 8'd0, '1, '1));
    send_item(item_of(OP_BYTE, '0, '0, 8'h00, 64'h0));
    send_item(item_of(OP_BYTE, '1, '1, 8'hFF, '1));
    send_item(item_of(OP_BYTE, '0, '0, 8'hA5, 64'h5A5A_5A5A_5A5A_5A5A));
    send_item(item_of(OP_STATUS, 4'h3, 8'd9, '0, '0));       // epoch moves between bytes
    send_item(item_of(OP_BYTE, '0, '0, 8'h5A, 64'hA5A5_A5A5_A5A5_A5A5));
    repeat (4) send_item(item_of(OP_POP, '1, '1, '1, '1));
    send_item(item_of(OP_POP, '0, '0, '0, '0));              // empty again
  endtask

  // Fill past capacity so bytes drop, toggle around full, then leave it near full
  task automatic test_ring_full();
    repeat (RING_SLOTS + 8) send_item(rand_item(OP_BYTE));
    repeat (3) begin
      send_item(rand_item(OP_POP));
      send_item(rand_item(OP_BYTE));
      send_item(rand_item(OP_BYTE));
      send_item(rand_item(OP_STATUS));
    end
    repeat (40) send_item(rand_item(OP_POP));
  endtask

  // Result side holds off long enough that the block stalls its input
  task automatic test_long_stall();
    hold_asked++;
    repeat (48) send_item(rand_item(pick_op(MIX_EVEN)));
  endtask

  // Random phases that push the ring toward full, toward empty, or keep it level
  task automatic test_random_mix();
    int unsigned sent;
    int unsigned chunk;
    op_mix_e     mix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      chunk = $urandom_range(40, 160);
      mix   = op_mix_e'($urandom_range(0, 2));
      repeat (chunk) send_item(rand_item(pick_op(mix)));
      sent += chunk;
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    rx_result_t want;
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (rx_results_due.size() == 0) begin
        $error("Result beat arrived with no request outstanding");
        error_count++;
      end else begin
        want = rx_results_due.pop_front();
        check_field("pop_valid", 64'(want.pop_valid), 64'(rsp.pop_valid));
        check_field("pop_time", want.pop_time, rsp.pop_time);
        check_field("pop_epoch", 64'(want.pop_epoch), 64'(rsp.pop_epoch));
        check_field("pop_value", 64'(want.pop_value), 64'(rsp.pop_value));
        check_field("byte_total", 64'(want.byte_total), 64'(rsp.byte_total));
        check_field("drop_total", 64'(want.drop_total), 64'(rsp.drop_total));
        check_field("overflow_total", 64'(want.overflow_total), 64'(rsp.overflow_total));
        check_field("framing_total", 64'(want.framing_total), 64'(rsp.framing_total));
        check_field("parity_total", 64'(want.parity_total), 64'(rsp.parity_total));
        check_field("break_total", 64'(want.break_total), 64'(rsp.break_total));
        check_field("batch_peak", 64'(want.batch_peak), 64'(rsp.batch_peak));
        results_checked++;
        if (want.pop_valid) pops_with_data++;
      end
    end
  end

  // Result-side ready: long hold on request, else a mode that changes now and then
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_done) begin
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        if (sink_phase == 0) begin
          sink_mode  = sink_mode_e'($urandom_range(0, 3));
          sink_phase = $urandom_range(16, 96);
        end
        sink_phase--;
        case (sink_mode)
          SINK_OPEN:   rsp.ready <= 1'b1;
          SINK_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: rsp.ready <= (sink_phase % 4 == 0);
          default:     rsp.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Watchdog: too long without any beat on either side
  always @(posedge clk) begin
    if ((req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    ring_head     = 0;
    ring_tail     = 0;
    epoch_now     = '0;
    bytes_seen    = '0;
    bytes_dropped = '0;
    overflow_seen = '0;
    framing_seen  = '0;
    parity_seen   = '0;
    break_seen    = '0;
    peak_len      = '0;
    req.valid        <= 1'b0;
    req.op           <= OP_STATUS;
    req.error_flags  <= '0;
    req.batch_len    <= '0;
    req.byte_value   <= '0;
    req.arrival_time <= '0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_ring_full();
    test_long_stall();
    test_random_mix();
    req.valid <= 1'b0;

    while (rx_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request beats, checked %0d results, %0d pops returned data.",
             items_sent, results_checked, pops_with_data);
    $display("Ring saw %0d bytes with %0d dropped at full; final epoch %0d.",
             bytes_seen, bytes_dropped, epoch_now);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
